/* design/thx_pkg.sv */
`timescale 1ns / 1ps
package thx_pkg;

  localparam int MAX_SEQ_LEN_DEF   = 4096;
  localparam int ALPHABET_SIZE_DEF = 32;
  localparam int SCORE_WIDTH_DEF   = 16;

  localparam int CODE_W    = 5;
  localparam int TAB_AW    = 2 * CODE_W;
  localparam int TAB_DEPTH = 1 << TAB_AW;
  localparam int IDX_W     = 12;
  localparam int LEN_W     = 13;
  localparam int LV_W      = 16;
  localparam int BEST_W    = 24;
  localparam int XD_W      = 16;
  localparam int TRIG_W    = 16;
  localparam int WL_W      = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_TABLE   = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_SUBJECT = 2'd2;
  localparam logic [1:0] KIND_EXTEND  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_X_DROP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_SCORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH  = 2'd3;

  typedef struct packed {
    logic [XD_W-1:0]   x_drop;
    logic [TRIG_W-1:0] trigger_score;
    logic [WL_W-1:0]   word_length;
    logic [LEN_W-1:0]  query_length;
  } cfg_t;

endpackage

/* design/thx_ram.sv */
`timescale 1ns / 1ps
module thx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/thx_ext.sv */
`timescale 1ns / 1ps
module thx_ext #(
  parameter int MAX_SEQ_LEN   = 4096,
  parameter int ALPHABET_SIZE = 32,
  parameter int SCORE_WIDTH   = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  thx_pkg::cfg_t                          cfg_i,
  input  logic                                   start_i,
  input  logic [thx_pkg::IDX_W-1:0]              first_hit_subject_i,
  input  logic [thx_pkg::IDX_W-1:0]              second_hit_subject_i,
  input  logic [thx_pkg::IDX_W-1:0]              second_hit_query_i,
  input  logic [thx_pkg::LEN_W-1:0]              subject_length_i,
  output logic                                   busy_o,
  output logic [$clog2(MAX_SEQ_LEN)-1:0]         qaddr_o,
  output logic [$clog2(MAX_SEQ_LEN)-1:0]         saddr_o,
  output logic [thx_pkg::TAB_AW-1:0]             taddr_o,
  input  logic [thx_pkg::CODE_W-1:0]             qdata_i,
  input  logic [thx_pkg::CODE_W-1:0]             sdata_i,
  input  logic [SCORE_WIDTH-1:0]                 tdata_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [thx_pkg::BEST_W-1:0]             best_score_o,
  output logic [thx_pkg::LEN_W-1:0]              query_start_o,
  output logic [thx_pkg::LEN_W-1:0]              subject_start_o,
  output logic [thx_pkg::LEN_W-1:0]              hsp_length_o,
  output logic [thx_pkg::LEN_W-1:0]              subject_end_reached_o,
  output logic                                   right_extended_o,
  output logic                                   passes_trigger_o
);
  import thx_pkg::*;

  localparam int AW    = $clog2(MAX_SEQ_LEN);
  localparam int PW    = ((AW > IDX_W) ? AW : IDX_W) + 2;
  localparam int ACC_W = SCORE_WIDTH + PW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_TB   = 3'd2;
  localparam logic [2:0] S_AC   = 3'd3;
  localparam logic [2:0] S_LST  = 3'd4;
  localparam logic [2:0] S_RST  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] P_WORD  = 2'd0;
  localparam logic [1:0] P_LEFT  = 2'd1;
  localparam logic [1:0] P_RIGHT = 2'd2;

  localparam logic signed [PW-1:0]    MAXP   = PW'(MAX_SEQ_LEN);
  localparam logic signed [ACC_W-1:0] SAT24  = ACC_W'((1 << BEST_W) - 1);
  localparam logic [CODE_W:0]         ALPH_C = (CODE_W + 1)'(ALPHABET_SIZE);

  logic [2:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic signed [PW-1:0] qh_q, qh_d, sh_q, sh_d, fh_q, fh_d, slen_q, slen_d, qlen_q, qlen_d;
  logic signed [PW-1:0] qr_q, qr_d, sr_q, sr_d, qp_q, qp_d, sp_q, sp_d, nr_q, nr_d;
  logic signed [PW-1:0] cnt_q, cnt_d, llen_q, llen_d, rlen_q, rlen_d, last_q, last_d;
  logic [WL_W-1:0] shift_q, shift_d;
  logic signed [ACC_W-1:0] sc_q, sc_d, mx_q, mx_d;
  logic [1:0] oob_q, oob_d;
  logic z_q, z_d, ran_q, ran_d;
  logic out_valid_q, out_valid_d;
  logic [BEST_W-1:0] best_q, best_d;
  logic [LEN_W-1:0] qs_q, qs_d, ss_q, ss_d, hl_q, hl_d, se_q, se_d;
  logic re_q, re_d, pt_q, pt_d;

  logic [CODE_W-1:0] qc, scd;
  logic signed [ACC_W-1:0] ps, sc_n, mx_n, xd_s;
  logic imp, drop;
  logic signed [PW-1:0] qr_n, sr_n, dq, ds, slen_in, qlen_in;

  assign qc      = oob_q[0] ? '0 : qdata_i;
  assign scd     = oob_q[1] ? '0 : sdata_i;
  assign taddr_o = {qc, scd};
  assign qaddr_o = qp_q[AW-1:0];
  assign saddr_o = sp_q[AW-1:0];
  assign busy_o  = (st_q != S_IDLE);

  assign ps   = z_q ? '0 : ACC_W'($signed(tdata_i));
  assign sc_n = sc_q + ps;
  assign imp  = (sc_n > mx_q);
  assign mx_n = imp ? sc_n : mx_q;
  assign xd_s = $signed(ACC_W'(cfg_i.x_drop));
  assign drop = ((mx_n - sc_n) >= xd_s);
  assign qr_n = qh_q + $signed(PW'(shift_q));
  assign sr_n = sh_q + $signed(PW'(shift_q));
  assign dq   = qlen_q - qr_q;
  assign ds   = slen_q - sr_q;
  assign slen_in = ($signed(PW'(subject_length_i)) > MAXP) ? MAXP
                                                           : $signed(PW'(subject_length_i));
  assign qlen_in = ($signed(PW'(cfg_i.query_length)) > MAXP) ? MAXP
                                                             : $signed(PW'(cfg_i.query_length));

  always_comb begin
    st_d = st_q; ph_d = ph_q;
    qh_d = qh_q; sh_d = sh_q; fh_d = fh_q; slen_d = slen_q; qlen_d = qlen_q;
    qr_d = qr_q; sr_d = sr_q; qp_d = qp_q; sp_d = sp_q; nr_d = nr_q;
    cnt_d = cnt_q; llen_d = llen_q; rlen_d = rlen_q; last_d = last_q;
    shift_d = shift_q; sc_d = sc_q; mx_d = mx_q;
    oob_d = oob_q; z_d = z_q; ran_d = ran_q;
    out_valid_d = out_valid_q && out_stall_i;
    best_d = best_q; qs_d = qs_q; ss_d = ss_q; hl_d = hl_q; se_d = se_q;
    re_d = re_q; pt_d = pt_q;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          qh_d    = $signed(PW'(second_hit_query_i));
          sh_d    = $signed(PW'(second_hit_subject_i));
          fh_d    = $signed(PW'(first_hit_subject_i));
          slen_d  = slen_in;
          qlen_d  = qlen_in;
          qp_d    = $signed(PW'(second_hit_query_i));
          sp_d    = $signed(PW'(second_hit_subject_i));
          sc_d    = '0;
          mx_d    = '0;
          cnt_d   = '0;
          shift_d = '0;
          ph_d    = P_WORD;
          st_d    = (cfg_i.word_length == '0) ? S_LST : S_RD;
        end
      end
      S_RD: begin
        oob_d = {(sp_q < 0) || (sp_q >= MAXP), (qp_q < 0) || (qp_q >= MAXP)};
        st_d  = S_TB;
      end
      S_TB: begin
        z_d  = ({1'b0, qc} >= ALPH_C) || ({1'b0, scd} >= ALPH_C);
        st_d = S_AC;
      end
      S_AC: begin
        sc_d = sc_n;
        mx_d = mx_n;
        case (ph_q)
          P_WORD: begin
            if (imp) begin
              shift_d = WL_W'(cnt_q + 1);
            end
            cnt_d = PW'(cnt_q + 1);
            qp_d  = PW'(qp_q + 1);
            sp_d  = PW'(sp_q + 1);
            st_d  = ((cnt_q + 1) >= $signed(PW'(cfg_i.word_length))) ? S_LST : S_RD;
          end
          P_LEFT: begin
            if (imp) begin
              llen_d = PW'(cnt_q + 1);
            end
            cnt_d = PW'(cnt_q + 1);
            qp_d  = PW'(qp_q - 1);
            sp_d  = PW'(sp_q - 1);
            st_d  = (drop || qp_q == 0 || sp_q == 0) ? S_RST : S_RD;
          end
          default: begin
            if (imp) begin
              rlen_d = PW'(cnt_q + 1);
            end
            if (sc_n <= 0 || drop) begin
              last_d = sp_q;
              st_d   = S_FIN;
            end else if ((cnt_q + 1) >= nr_q) begin
              last_d = PW'(sp_q + 1);
              st_d   = S_FIN;
            end else begin
              cnt_d = PW'(cnt_q + 1);
              qp_d  = PW'(qp_q + 1);
              sp_d  = PW'(sp_q + 1);
              st_d  = S_RD;
            end
          end
        endcase
      end
      S_LST: begin
        qr_d   = qr_n;
        sr_d   = sr_n;
        qp_d   = PW'(qr_n - 1);
        sp_d   = PW'(sr_n - 1);
        sc_d   = '0;
        mx_d   = '0;
        llen_d = '0;
        cnt_d  = '0;
        ph_d   = P_LEFT;
        st_d   = (qr_n == 0 || sr_n == 0) ? S_RST : S_RD;
      end
      S_RST: begin
        rlen_d = '0;
        last_d = sr_q;
        if (llen_q >= (sr_q - fh_q)) begin
          ran_d = 1'b1;
          nr_d  = (ds < dq) ? ds : dq;
          cnt_d = '0;
          sc_d  = mx_q;
          qp_d  = qr_q;
          sp_d  = sr_q;
          ph_d  = P_RIGHT;
          st_d  = (((ds < dq) ? ds : dq) <= 0) ? S_FIN : S_RD;
        end else begin
          ran_d = 1'b0;
          st_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          best_d = (mx_q > SAT24) ? SAT24[BEST_W-1:0] : mx_q[BEST_W-1:0];
          pt_d   = (mx_q >= $signed(ACC_W'(cfg_i.trigger_score)));
          qs_d   = LEN_W'(qr_q - llen_q);
          ss_d   = LEN_W'(sr_q - llen_q);
          hl_d   = LEN_W'(llen_q + rlen_q);
          se_d   = LEN_W'(last_q);
          re_d   = ran_q;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ph_q        <= P_WORD;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qh_q <= qh_d; sh_q <= sh_d; fh_q <= fh_d; slen_q <= slen_d; qlen_q <= qlen_d;
    qr_q <= qr_d; sr_q <= sr_d; qp_q <= qp_d; sp_q <= sp_d; nr_q <= nr_d;
    cnt_q <= cnt_d; llen_q <= llen_d; rlen_q <= rlen_d; last_q <= last_d;
    shift_q <= shift_d; sc_q <= sc_d; mx_q <= mx_d;
    oob_q <= oob_d; z_q <= z_d; ran_q <= ran_d;
    best_q <= best_d; qs_q <= qs_d; ss_q <= ss_d; hl_q <= hl_d; se_q <= se_d;
    re_q <= re_d; pt_q <= pt_d;
  end

  assign out_valid_o           = out_valid_q;
  assign best_score_o          = best_q;
  assign query_start_o         = qs_q;
  assign subject_start_o       = ss_q;
  assign hsp_length_o          = hl_q;
  assign subject_end_reached_o = se_q;
  assign right_extended_o      = re_q;
  assign passes_trigger_o      = pt_q;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && start_i) |=> busy_o)
    else $error("extension did not start");

  a_best_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN) |-> (mx_q >= 0))
    else $error("best score negative");

  a_left_only_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !right_extended_o) |->
      (LEN_W'(subject_start_o + hsp_length_o) == subject_end_reached_o))
    else $error("left-only result inconsistent");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && out_valid_o && out_stall_i) |=> (st_q == S_FIN))
    else $error("result dropped while output stalled");
`endif

endmodule

/* design/two_hit_xdrop_ungapped_extension.sv */
`timescale 1ns / 1ps
// Two-hit ungapped X-drop extension for protein sequences.
// Input channel (in_valid_i / in_stall_o): each item is a load or an extend
// request, selected by kind_i. Loads write the score table, the query store
// or the subject store in the cycle they are accepted and give no result.
// An extend request gives exactly one result item on the output channel
// (out_valid_o / out_stall_i).
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is high,
// only while no extension is in flight.
// Steps: for each residue visited in the word scan, the left scan and the right
// scan, an extend request does a sequence store read, a table read and an
// accumulate; left setup, right setup and finish states come on top. The result
// register is loaded in finish. in_stall_o stays high for the whole extension;
// loads are taken one per cycle while no extension is running.
// A finished result sits in the output register; the next item is accepted
// while it waits. If a second result is ready while the first is stalled,
// the block holds it and keeps in_stall_o high.
// Reset: control state clears, configuration returns to its defaults, the
// stores keep undefined contents until written.
module two_hit_xdrop_ungapped_extension #(
  parameter int MAX_SEQ_LEN   = thx_pkg::MAX_SEQ_LEN_DEF,
  parameter int ALPHABET_SIZE = thx_pkg::ALPHABET_SIZE_DEF,
  parameter int SCORE_WIDTH   = thx_pkg::SCORE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [thx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [thx_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [thx_pkg::IDX_W-1:0]     load_index_i,
  input  logic signed [thx_pkg::LV_W-1:0] load_value_i,
  input  logic [thx_pkg::IDX_W-1:0]     first_hit_subject_i,
  input  logic [thx_pkg::IDX_W-1:0]     second_hit_subject_i,
  input  logic [thx_pkg::IDX_W-1:0]     second_hit_query_i,
  input  logic [thx_pkg::LEN_W-1:0]     subject_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [thx_pkg::BEST_W-1:0]    best_score_o,
  output logic [thx_pkg::LEN_W-1:0]     query_start_o,
  output logic [thx_pkg::LEN_W-1:0]     subject_start_o,
  output logic [thx_pkg::LEN_W-1:0]     hsp_length_o,
  output logic [thx_pkg::LEN_W-1:0]     subject_end_reached_o,
  output logic                          right_extended_o,
  output logic                          passes_trigger_o
);
  import thx_pkg::*;

  localparam int AW = $clog2(MAX_SEQ_LEN);
  localparam int XW = AW + IDX_W;
  localparam logic [CODE_W:0] ALPH_C = (CODE_W + 1)'(ALPHABET_SIZE);

  cfg_t cfg_q, cfg_d;
  logic acc, busy;
  logic [XW-1:0] idx_x;
  logic seq_ok, tab_ok;
  logic q_we, s_we, t_we;
  logic [AW-1:0] q_addr, s_addr, eq_addr, es_addr;
  logic [TAB_AW-1:0] t_addr, et_addr;
  logic [CODE_W-1:0] q_rd, s_rd;
  logic [SCORE_WIDTH-1:0] t_rd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_DROP:        cfg_d.x_drop        = cfg_data_i[XD_W-1:0];
        REG_TRIGGER_SCORE: cfg_d.trigger_score = cfg_data_i[TRIG_W-1:0];
        REG_WORD_LENGTH:   cfg_d.word_length   = cfg_data_i[WL_W-1:0];
        REG_QUERY_LENGTH:  cfg_d.query_length  = cfg_data_i[LEN_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_drop        <= XD_W'(16);
      cfg_q.trigger_score <= TRIG_W'(22);
      cfg_q.word_length   <= WL_W'(3);
      cfg_q.query_length  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;
  assign idx_x      = XW'(load_index_i);
  assign seq_ok     = (idx_x < XW'(MAX_SEQ_LEN));
  assign tab_ok     = (load_index_i < IDX_W'(TAB_DEPTH))
                   && ({1'b0, load_index_i[TAB_AW-1:CODE_W]} < ALPH_C)
                   && ({1'b0, load_index_i[CODE_W-1:0]} < ALPH_C);

  assign t_we = acc && (kind_i == KIND_TABLE) && tab_ok;
  assign q_we = acc && (kind_i == KIND_QUERY) && seq_ok;
  assign s_we = acc && (kind_i == KIND_SUBJECT) && seq_ok;

  assign q_addr = busy ? eq_addr : idx_x[AW-1:0];
  assign s_addr = busy ? es_addr : idx_x[AW-1:0];
  assign t_addr = busy ? et_addr : load_index_i[TAB_AW-1:0];

  thx_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(TAB_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .addr_i  (t_addr),
    .wdata_i (load_value_i[SCORE_WIDTH-1:0]),
    .rdata_o (t_rd)
  );

  thx_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SEQ_LEN)) u_query (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .addr_i  (q_addr),
    .wdata_i (load_value_i[CODE_W-1:0]),
    .rdata_o (q_rd)
  );

  thx_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SEQ_LEN)) u_subject (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .addr_i  (s_addr),
    .wdata_i (load_value_i[CODE_W-1:0]),
    .rdata_o (s_rd)
  );

  thx_ext #(
    .MAX_SEQ_LEN   (MAX_SEQ_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .SCORE_WIDTH   (SCORE_WIDTH)
  ) u_ext (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .start_i               (acc && (kind_i == KIND_EXTEND)),
    .first_hit_subject_i   (first_hit_subject_i),
    .second_hit_subject_i  (second_hit_subject_i),
    .second_hit_query_i    (second_hit_query_i),
    .subject_length_i      (subject_length_i),
    .busy_o                (busy),
    .qaddr_o               (eq_addr),
    .saddr_o               (es_addr),
    .taddr_o               (et_addr),
    .qdata_i               (q_rd),
    .sdata_i               (s_rd),
    .tdata_i               (t_rd),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .best_score_o          (best_score_o),
    .query_start_o         (query_start_o),
    .subject_start_o       (subject_start_o),
    .hsp_length_o          (hsp_length_o),
    .subject_end_reached_o (subject_end_reached_o),
    .right_extended_o      (right_extended_o),
    .passes_trigger_o      (passes_trigger_o)
  );

endmodule

/* tb/sv/two_hit_xdrop_ungapped_extension_tb.sv */
`timescale 1ns / 1ps
module two_hit_xdrop_ungapped_extension_tb;
  import thx_pkg::*;

  localparam int SPAN   = 640;
  localparam int TOP_LO = 4080;
  localparam int NCODES = 8;

  typedef struct {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        idx;
    logic signed [LV_W-1:0]  val;
    logic [IDX_W-1:0]        fh;
    logic [IDX_W-1:0]        sh;
    logic [IDX_W-1:0]        qh;
    logic [LEN_W-1:0]        slen;
  } req_t;

  typedef struct packed {
    logic [BEST_W-1:0] best;
    logic [LEN_W-1:0]  qstart;
    logic [LEN_W-1:0]  sstart;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  send;
    logic              rext;
    logic              pass;
  } hsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_TABLE;
  logic [IDX_W-1:0] load_index_i = '0;
  logic signed [LV_W-1:0] load_value_i = '0;
  logic [IDX_W-1:0] first_hit_subject_i = '0;
  logic [IDX_W-1:0] second_hit_subject_i = '0;
  logic [IDX_W-1:0] second_hit_query_i = '0;
  logic [LEN_W-1:0] subject_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BEST_W-1:0] best_score_o;
  logic [LEN_W-1:0] query_start_o, subject_start_o, hsp_length_o, subject_end_reached_o;
  logic right_extended_o, passes_trigger_o;

  two_hit_xdrop_ungapped_extension u_dut (.*);

  always #5 clk_i = ~clk_i;

  logic signed [15:0] score_tab [TAB_DEPTH];
  logic [4:0] query_res [4096];
  logic [4:0] subject_res [4096];
  logic [XD_W-1:0] xdrop_reg;
  logic [TRIG_W-1:0] trigger_reg;
  logic [WL_W-1:0] wlen_reg;
  logic [LEN_W-1:0] qlen_reg;

  hsp_t hsp_q[$];
  bit calm = 1'b0;
  int mismatches = 0;
  int hsps_checked = 0;
  int loads_sent = 0;

  function automatic longint pair_at(longint qpos, longint spos);
    longint qc, sc;
    qc = (qpos < 0 || qpos >= 4096) ? 0 : query_res[qpos];
    sc = (spos < 0 || spos >= 4096) ? 0 : subject_res[spos];
    return score_tab[qc * 32 + sc];
  endfunction

  function automatic logic [LEN_W-1:0] clamp13(longint v);
    if (v < 0) return '0;
    if (v > 8191) return 13'h1FFF;
    return v[12:0];
  endfunction

  function automatic hsp_t predict_hsp(req_t r);
    longint fh, sr, qr, slen, qlen, xd, acc, wbest, shift, last, n, i, bi, sc, mx;
    longint left_len, right_len, lscore, rscore, best;
    bit ran;
    hsp_t h;
    fh = r.fh;
    slen = (r.slen > 4096) ? 4096 : r.slen;
    qlen = (qlen_reg > 4096) ? 4096 : qlen_reg;
    xd = xdrop_reg;
    acc = 0; wbest = 0; shift = 0;
    right_len = 0; rscore = 0; ran = 0;
    for (i = 0; i < wlen_reg; i++) begin
      acc += pair_at(r.qh + i, r.sh + i);
      if (acc > wbest) begin
        wbest = acc;
        shift = i + 1;
      end
    end
    qr = r.qh + shift;
    sr = r.sh + shift;
    last = sr;
    n = (sr < qr) ? sr - 1 : qr - 1;
    bi = n + 1; sc = 0; mx = 0;
    for (i = n; i >= 0; i--) begin
      sc += pair_at(qr - 1 - n + i, sr - 1 - n + i);
      if (sc > mx) begin
        mx = sc;
        bi = i;
      end
      if (mx - sc >= xd) break;
    end
    left_len = n - bi + 1;
    lscore = mx;
    if (left_len >= sr - fh) begin
      ran = 1;
      n = (slen - sr < qlen - qr) ? slen - sr : qlen - qr;
      bi = -1; sc = mx;
      for (i = 0; i < n; i++) begin
        sc += pair_at(qr + i, sr + i);
        if (sc > mx) begin
          mx = sc;
          bi = i;
        end
        if (sc <= 0 || mx - sc >= xd) break;
      end
      right_len = bi + 1;
      last = sr + i;
      rscore = mx;
    end
    best = (lscore > rscore) ? lscore : rscore;
    h.best = (best > 16777215) ? 24'hFFFFFF : ((best < 0) ? '0 : best[23:0]);
    h.qstart = clamp13(qr - left_len);
    h.sstart = clamp13(sr - left_len);
    h.len = clamp13(left_len + right_len);
    h.send = clamp13(last);
    h.rext = ran;
    h.pass = (best >= trigger_reg);
    return h;
  endfunction

  task automatic send_item(req_t r);
    if (!calm && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = r.kind;
    load_index_i = r.idx;
    load_value_i = r.val;
    first_hit_subject_i = r.fh;
    second_hit_subject_i = r.sh;
    second_hit_query_i = r.qh;
    subject_length_i = r.slen;
    do @(posedge clk_i); while (in_stall_o);
    case (r.kind)
      KIND_TABLE: if (r.idx < TAB_DEPTH) score_tab[r.idx] = r.val;
      KIND_QUERY: query_res[r.idx] = r.val[4:0];
      KIND_SUBJECT: subject_res[r.idx] = r.val[4:0];
      default: hsp_q.push_back(predict_hsp(r));
    endcase
    if (r.kind != KIND_EXTEND) loads_sent++;
  endtask

  task automatic load(logic [1:0] kind, int idx, int val);
    req_t r;
    r = '{kind, idx[11:0], val[15:0], IDX_W'($urandom), IDX_W'($urandom),
          IDX_W'($urandom), LEN_W'($urandom)};
    send_item(r);
  endtask

  task automatic extend(int fh, int sh, int qh, int slen);
    req_t r;
    r = '{KIND_EXTEND, IDX_W'($urandom), LV_W'($urandom), fh[11:0], sh[11:0], qh[11:0],
          slen[12:0]};
    send_item(r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (hsp_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[15:0];
    case (idx)
      REG_X_DROP: xdrop_reg = val[15:0];
      REG_TRIGGER_SCORE: trigger_reg = val[15:0];
      REG_WORD_LENGTH: wlen_reg = val[3:0];
      default: qlen_reg = val[12:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic int small_score();
    return int'($urandom_range(11)) - 6;
  endfunction

  function automatic int seq_code();
    return int'($urandom & 32'hFFFF_FFE0) | int'($urandom_range(NCODES - 1));
  endfunction

  task automatic fill_table(bit maxed);
    for (int q = 0; q < NCODES; q++)
      for (int s = 0; s < NCODES; s++)
        load(KIND_TABLE, q * 32 + s, maxed ? 32767 : small_score());
  endtask

  task automatic test_fill_stores();
    fill_table(1'b0);
    for (int i = 0; i < SPAN; i++) load(KIND_QUERY, i, seq_code());
    for (int i = TOP_LO; i < 4096; i++) load(KIND_QUERY, i, seq_code());
    for (int i = 0; i < SPAN; i++) load(KIND_SUBJECT, i, seq_code());
    for (int i = TOP_LO; i < 4096; i++) load(KIND_SUBJECT, i, seq_code());
    load(KIND_TABLE, 4095, 32767);
    load(KIND_TABLE, 1024, -32768);
  endtask

  task automatic test_directed();
    write_reg(REG_QUERY_LENGTH, SPAN);
    extend(100, 110, 200, SPAN);
    extend(0, 5, 4090, 8191);
    extend(0, 0, 0, 0);
    extend(4095, 10, 20, SPAN);
    write_reg(REG_WORD_LENGTH, 0);
    extend(50, 60, 60, SPAN);
    write_reg(REG_WORD_LENGTH, 15);
    // one side runs off the top of its store while the other stays inside
    extend(0, 5, 4094, SPAN);
    extend(0, 4094, 5, 8191);
    write_reg(REG_X_DROP, 0);
    extend(300, 305, 400, SPAN);
    write_reg(REG_TRIGGER_SCORE, 0);
    extend(200, 200, 200, SPAN);
    write_reg(REG_TRIGGER_SCORE, 65535);
    write_reg(REG_QUERY_LENGTH, 8191);
    extend(300, 300, 250, SPAN);
    write_reg(REG_QUERY_LENGTH, SPAN);
    // push the score past the 24-bit limit on an all-maximum table
    fill_table(1'b1);
    write_reg(REG_X_DROP, 65535);
    write_reg(REG_WORD_LENGTH, 8);
    extend(0, 320, 320, SPAN);
    extend(0, 200, 300, SPAN);
    fill_table(1'b0);
    write_reg(REG_X_DROP, 1);
    extend(20, 40, 40, SPAN);
  endtask

  task automatic test_random();
    int sh, qh, fh, slen, pick, tmp;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_X_DROP, (phase == 3) ? 200 : $urandom_range(1, 40));
      write_reg(REG_TRIGGER_SCORE, $urandom_range(0, 60));
      write_reg(REG_WORD_LENGTH, $urandom_range(1, 8));
      write_reg(REG_QUERY_LENGTH, (phase % 3 == 0) ? $urandom_range(0, 8191) : SPAN);
      calm = (phase == 5);
      for (int k = 0; k < 70; k++) begin
        pick = $urandom_range(99);
        if (pick < 15) load(KIND_TABLE, $urandom_range(0, 1100),
                            ($urandom_range(19) == 0) ? $urandom : small_score());
        else if (pick < 30) load(2'($urandom_range(1, 2)), $urandom_range(0, 4095),
                                 seq_code());
        else begin
          sh = $urandom_range(0, SPAN - 16);
          qh = $urandom_range(0, SPAN - 16);
          pick = $urandom_range(99);
          if (pick < 70) fh = sh - $urandom_range(0, (sh < 30) ? sh : 30);
          else if (pick < 80) fh = $urandom_range(sh, 4095);
          else fh = $urandom_range(0, 4095);
          if (qlen_reg > SPAN) begin
            if (qh > sh) begin
              tmp = qh;
              qh = sh;
              sh = tmp;
            end
            slen = $urandom_range(0, SPAN);
          end else if (sh <= qh && $urandom_range(4) == 0) begin
            slen = $urandom_range(4097, 8191);
          end else begin
            slen = $urandom_range(0, SPAN);
          end
          extend(fh, sh, qh, slen);
        end
      end
      calm = 1'b0;
    end
  endtask

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 24);

  always @(posedge clk_i) begin
    hsp_t e, a;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      a = '{best_score_o, query_start_o, subject_start_o, hsp_length_o,
            subject_end_reached_o, right_extended_o, passes_trigger_o};
      if (hsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
      end else begin
        e = hsp_q.pop_front();
        hsps_checked++;
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
        end
      end
    end
  end

  initial begin
    xdrop_reg = 16;
    trigger_reg = 22;
    wlen_reg = 3;
    qlen_reg = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill_stores();
    test_directed();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (hsp_q.size() != 0) mismatches++;
    $display("checked %0d extensions and %0d loads over varied register settings",
             hsps_checked, loads_sent);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
